// ===== rtl/core/mesi_lsm_pkg.sv =====
package mesi_lsm_pkg;

  localparam int unsigned NumSetsDef = 16384;
  localparam int unsigned NumWaysDef = 8;

  // fixed field widths
  localparam int unsigned CmdW    = 3;
  localparam int unsigned SetIdxW = 14;
  localparam int unsigned WaySelW = 3;
  localparam int unsigned SnoopW  = 2;
  localparam int unsigned BusOpW  = 3;
  localparam int unsigned LineW   = 2;

  typedef enum logic [LineW-1:0] {
    LINE_I = 2'd0,
    LINE_S = 2'd1,
    LINE_E = 2'd2,
    LINE_M = 2'd3
  } line_state_e;

  typedef enum logic [CmdW-1:0] {
    EV_PR    = 3'd0,
    EV_PW    = 3'd1,
    EV_PIR   = 3'd2,
    EV_SR    = 3'd3,
    EV_SW    = 3'd4,
    EV_SRWIM = 3'd5,
    EV_SINV  = 3'd6,
    EV_UNUSED = 3'd7
  } event_e;

  typedef enum logic [BusOpW-1:0] {
    BUS_NONE  = 3'd0,
    BUS_READ  = 3'd1,
    BUS_WRITE = 3'd2,
    BUS_INV   = 3'd3,
    BUS_RWIM  = 3'd4
  } bus_op_e;

  typedef enum logic [1:0] {
    RSP_NONE  = 2'd0,
    RSP_NOHIT = 2'd1,
    RSP_HIT   = 2'd2,
    RSP_HITM  = 2'd3
  } snoop_rsp_e;

  typedef enum logic [1:0] {
    CTRL_CLEAR  = 2'd0,
    CTRL_IDLE   = 2'd1,
    CTRL_LOOKUP = 2'd2
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;    // write a zero row at the sweep counter and advance it
    logic capture;  // latch the input fields and read their row
    logic update;   // write the row back and load the result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_row;
  } dp_status_t;

endpackage

// ===== rtl/core/mesi_lsm_ctrl.sv =====
module mesi_lsm_ctrl
  import mesi_lsm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTRL_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    case (state_q)
      CTRL_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.last_row) state_d = CTRL_IDLE;
      end
      CTRL_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = CTRL_LOOKUP;
        end
      end
      CTRL_LOOKUP: begin
        // hold the read row until the result register can take the transfer
        if (out_free) begin
          cmd_o.update = 1'b1;
          state_d      = CTRL_IDLE;
        end
      end
      default: state_d = CTRL_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.update) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  a_update_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while a transfer is pending");

  a_update_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.update |=> out_valid_o)
    else $error("update did not present a result");

  a_capture_then_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == CTRL_LOOKUP && !in_ready_o))
    else $error("capture not followed by lookup");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |-> !(cmd_o.capture || cmd_o.update))
    else $error("item handled during clearing sweep");

endmodule

// ===== rtl/core/mesi_lsm_dp.sv =====
module mesi_lsm_dp
  import mesi_lsm_pkg::*;
#(
  parameter int unsigned NUM_SETS = NumSetsDef,
  parameter int unsigned NUM_WAYS = NumWaysDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  input  logic [CmdW-1:0]    command_i,
  input  logic [SetIdxW-1:0] set_index_i,
  input  logic [WaySelW-1:0] way_select_i,
  input  logic [SnoopW-1:0]  snoop_result_i,
  output logic [BusOpW-1:0]  bus_operation_o,
  output logic [1:0]         snoop_response_o,
  output logic [1:0]         snoop_seen_o,
  output logic               evict_upper_o,
  output logic               bad_transition_o,
  output logic [LineW-1:0]   next_state_o
);

  localparam int unsigned SetW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WayW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned RowW = NUM_WAYS * LineW;

  logic [RowW-1:0]    mem_q [NUM_SETS];
  logic [RowW-1:0]    rd_row_q;
  logic [SetW-1:0]    clr_cnt_q;

  logic [CmdW-1:0]    cmd_q;
  logic [SetIdxW-1:0] set_q;
  logic [WaySelW-1:0] way_q;
  logic [SnoopW-1:0]  rep_q;

  logic [SetIdxW+SetW-1:0]  set_in_ext, set_q_ext;
  logic [WaySelW+WayW-1:0]  way_q_ext;
  logic [SetW-1:0]          rd_addr, up_addr;
  logic [WayW-1:0]          way_idx;
  logic                     in_range;

  logic [LineW-1:0]  cur, nxt;
  logic [BusOpW-1:0] bus;
  logic [1:0]        rsp, seen, sample;
  logic              evict, bad, proc_rd;
  logic [RowW-1:0]   wr_row;

  assign set_in_ext = {{SetW{1'b0}}, set_index_i};
  assign set_q_ext  = {{SetW{1'b0}}, set_q};
  assign way_q_ext  = {{WayW{1'b0}}, way_q};
  assign rd_addr    = set_in_ext[SetW-1:0];
  assign up_addr    = set_q_ext[SetW-1:0];
  assign way_idx    = way_q_ext[WayW-1:0];
  assign in_range   = (32'(set_q) < NUM_SETS) && (32'(way_q) < NUM_WAYS);

  assign status_o.last_row = (clr_cnt_q == SetW'(NUM_SETS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + SetW'(1);
    end
  end

  // line state store, one row per set
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) mem_q[clr_cnt_q] <= '0;
    else if (cmd_i.update && in_range) mem_q[up_addr] <= wr_row;
    if (cmd_i.capture) rd_row_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= command_i;
      set_q <= set_index_i;
      way_q <= way_select_i;
      rep_q <= snoop_result_i;
    end
  end

  assign cur     = rd_row_q[{way_idx, 1'b0} +: LineW];
  assign proc_rd = (cmd_q inside {EV_PR, EV_PIR});
  // report codes 2 and 3 read as hitm
  assign sample  = (rep_q >= 2'd2) ? RSP_HITM : rep_q + 2'd1;

  always_comb begin
    bus   = BUS_NONE;
    rsp   = RSP_NONE;
    seen  = RSP_NONE;
    evict = 1'b0;
    bad   = 1'b0;
    nxt   = cur;
    case (cur)
      LINE_M: begin
        if (proc_rd || cmd_q == EV_PW) begin
          seen = sample;
        end else if (cmd_q == EV_SR) begin
          rsp = RSP_HITM; bus = BUS_WRITE; nxt = LINE_S;
        end else if (cmd_q == EV_SRWIM) begin
          rsp = RSP_HITM; bus = BUS_WRITE; nxt = LINE_I; evict = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      LINE_E: begin
        if (proc_rd) begin
          seen = sample;
        end else if (cmd_q == EV_PW) begin
          seen = sample; nxt = LINE_M;
        end else if (cmd_q == EV_SR) begin
          rsp = RSP_HIT; nxt = LINE_S;
        end else if (cmd_q == EV_SRWIM) begin
          rsp = RSP_NOHIT; nxt = LINE_I; evict = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      LINE_S: begin
        if (proc_rd) begin
          seen = sample;
        end else if (cmd_q == EV_PW) begin
          seen = sample; bus = BUS_INV; nxt = LINE_M;
        end else if (cmd_q == EV_SR) begin
          rsp = RSP_HIT;
        end else if (cmd_q inside {EV_SINV, EV_SRWIM}) begin
          rsp = RSP_NOHIT; nxt = LINE_I; evict = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        if (proc_rd) begin
          seen = sample; bus = BUS_READ;
          nxt  = (sample inside {RSP_HIT, RSP_HITM}) ? LINE_S : LINE_E;
        end else if (cmd_q == EV_PW) begin
          seen = sample; bus = BUS_RWIM; nxt = LINE_M;
        end else if (cmd_q inside {[EV_SR:EV_SINV]}) begin
          rsp = RSP_NOHIT;
        end else begin
          bad = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    wr_row = rd_row_q;
    wr_row[{way_idx, 1'b0} +: LineW] = nxt;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      if (in_range) begin
        bus_operation_o  <= bus;
        snoop_response_o <= rsp;
        snoop_seen_o     <= seen;
        evict_upper_o    <= evict;
        bad_transition_o <= bad;
        next_state_o     <= nxt;
      end else begin
        bus_operation_o  <= BUS_NONE;
        snoop_response_o <= RSP_NONE;
        snoop_seen_o     <= RSP_NONE;
        evict_upper_o    <= 1'b0;
        bad_transition_o <= 1'b1;
        next_state_o     <= LINE_I;
      end
    end
  end

endmodule

// ===== rtl/core/mesi_line_state_machine_core.sv =====
// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------------
// in       | in_valid_i / in_ready_o   | command, set_index, way_select, snoop_result
// out      | out_valid_o / out_ready_i | bus_operation, snoop_response, snoop_seen,
//          |                           | evict_upper, bad_transition, next_state
//
// each item is a row read from the state store, then row write-back and result load; no new item is taken until then
// after reset a clearing sweep writes one set row per cycle, over all NUM_SETS rows, with in_ready_o low
// the result register frees the input side: a new transfer is taken while a result waits
// an item whose result cannot be loaded holds in lookup until out_ready_i frees the register
module mesi_line_state_machine_core
  import mesi_lsm_pkg::*;
#(
  parameter int unsigned NUM_SETS = NumSetsDef,
  parameter int unsigned NUM_WAYS = NumWaysDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CmdW-1:0]    command_i,
  input  logic [SetIdxW-1:0] set_index_i,
  input  logic [WaySelW-1:0] way_select_i,
  input  logic [SnoopW-1:0]  snoop_result_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [BusOpW-1:0]  bus_operation_o,
  output logic [1:0]         snoop_response_o,
  output logic [1:0]         snoop_seen_o,
  output logic               evict_upper_o,
  output logic               bad_transition_o,
  output logic [LineW-1:0]   next_state_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  mesi_lsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd),
    .status_i    (dp_status)
  );

  mesi_lsm_dp #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .status_o         (dp_status),
    .command_i        (command_i),
    .set_index_i      (set_index_i),
    .way_select_i     (way_select_i),
    .snoop_result_i   (snoop_result_i),
    .bus_operation_o  (bus_operation_o),
    .snoop_response_o (snoop_response_o),
    .snoop_seen_o     (snoop_seen_o),
    .evict_upper_o    (evict_upper_o),
    .bad_transition_o (bad_transition_o),
    .next_state_o     (next_state_o)
  );

endmodule
